// ===== design/dmps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmps_pkg;

   localparam int MAX_SIZE_DEFAULT = 128;
   localparam int CELL_W           = 16;
   localparam int SUM_W            = 24;
   localparam int CSR_W            = 8;

   // row position of a cell, decided when the cell is transferred
   typedef enum logic [1:0] {
      ROW_TOP   = 2'd0,
      ROW_UPPER = 2'd1,
      ROW_LOWER = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         use_left;
      logic         use_same;
      logic         row_end;
      logic         last_cell;
      logic         fwd_a;
      logic         fwd_b;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/diamond_max_path_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Maximum path sum down a diamond of 2*size-1 rows.
// Cells arrive on the req_ channel (valid/ready), row by row, left to right.
// The diamond size is written on the csr_ channel while the block is idle; the
// user must keep to this, the block does not enforce it. A write restarts the
// diamond. Values of 0 act as 1, above MAX_SIZE as MAX_SIZE. Only the bottom
// cell of a diamond gives a result on the rsp_ channel: the best total. Throughput
// is one cell per cycle while req_ready is high. A cell is transferred in the
// same cycle as its row-buffer reads issue; the update stage then adds the
// larger parent and writes the row buffer back (one write port, two registered
// read ports); a cell reading the column written that cycle gets it forwarded.
// The result sits in an output register, so cells keep flowing while it waits.
// If a bottom cell finishes while the previous total is still not taken,
// req_ready drops until rsp_ready frees the output register.
// Reset restores size 1 and starts a new diamond; the row buffer holds no
// valid state and needs no clearing, since every read follows a write
// of the same diamond.
module diamond_max_path_sum
   import dmps_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CELL_W-1:0] req_cell_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [SUM_W-1:0]  rsp_best_total,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_W-1:0]  csr_diamond_size
);

   localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int SW = $clog2(MAX_SIZE + 1);
   localparam int RW = SW + 1;
   localparam int EW = (SW > CSR_W) ? SW : CSR_W;

   logic [SW-1:0]    size_ff, size_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [SW-1:0]    col_ff, col_in;

   logic             s1_valid_ff, s1_valid_in;
   cell_ctrl_type    s1_ctrl_ff, s1_ctrl_in;
   logic [AW-1:0]    s1_addr_ff, s1_addr_in;
   logic [CELL_W-1:0] s1_value_ff, s1_value_in;
   logic [SUM_W-1:0] fwd_data_ff, fwd_data_in;
   logic [SUM_W-1:0] left_hold_ff, left_hold_in;

   logic             out_valid_ff, out_valid_in;
   logic [SUM_W-1:0] out_total_ff, out_total_in;

   logic             accept;
   logic             s1_hold;
   logic             s1_fire;
   logic [EW-1:0]    csr_ext;
   logic [RW-1:0]    size_r;
   logic [RW-1:0]    col_r;
   logic [RW-1:0]    rows_m1;
   logic [RW-1:0]    row_len;
   logic             row_done;
   logic [AW-1:0]    rd_addr_a;
   logic [AW-1:0]    rd_addr_b;
   logic [SUM_W-1:0] rd_data_a;
   logic [SUM_W-1:0] rd_data_b;
   logic [SUM_W-1:0] par_a;
   logic [SUM_W-1:0] par_b;
   logic [SUM_W-1:0] src_a;
   logic [SUM_W-1:0] src_b;
   logic [SUM_W-1:0] best;
   logic [SUM_W-1:0] sum;

   // ---------------- transfer stage: position and read issue ----------------
   assign s1_hold   = s1_valid_ff && s1_ctrl_ff.last_cell && out_valid_ff && !rsp_ready;
   assign s1_fire   = s1_valid_ff && !s1_hold;
   assign req_ready = !s1_hold;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   assign csr_ext = EW'(csr_diamond_size);
   assign size_r  = RW'(size_ff);
   assign col_r   = RW'(col_ff);
   assign rows_m1 = {size_r[RW-2:0], 1'b0} - RW'(1);
   assign row_len = (row_ff < size_r) ? (row_ff + RW'(1)) : (rows_m1 - row_ff);
   assign row_done = (col_r + RW'(1)) == row_len;

   assign rd_addr_a = col_ff[AW-1:0];
   assign rd_addr_b = AW'(col_ff + SW'(1));

   always_comb begin
      size_in     = size_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      s1_ctrl_in  = s1_ctrl_ff;
      s1_addr_in  = s1_addr_ff;
      s1_value_in = s1_value_ff;
      fwd_data_in = fwd_data_ff;
      s1_valid_in = s1_valid_ff && !s1_fire;

      if (csr_valid) begin
         priority if (csr_ext == EW'(0)) begin
            size_in = SW'(1);
         end else if (csr_ext > EW'(MAX_SIZE)) begin
            size_in = SW'(MAX_SIZE);
         end else begin
            size_in = SW'(csr_ext);
         end
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         s1_valid_in = 1'b1;
         priority if (row_ff == '0) begin
            s1_ctrl_in.kind = ROW_TOP;
         end else if (row_ff < size_r) begin
            s1_ctrl_in.kind = ROW_UPPER;
         end else begin
            s1_ctrl_in.kind = ROW_LOWER;
         end
         s1_ctrl_in.use_left  = col_ff != '0;
         s1_ctrl_in.use_same  = col_r < row_ff;
         s1_ctrl_in.row_end   = row_done;
         s1_ctrl_in.last_cell = row_done && (row_ff == rows_m1 - RW'(1));
         // the cell finishing this cycle writes while these reads issue
         s1_ctrl_in.fwd_a     = s1_valid_ff && (s1_addr_ff == rd_addr_a);
         s1_ctrl_in.fwd_b     = s1_valid_ff && (s1_addr_ff == rd_addr_b);
         fwd_data_in = sum;
         s1_addr_in  = rd_addr_a;
         s1_value_in = req_cell_value;
         if (row_done) begin
            col_in = '0;
            row_in = (row_ff == rows_m1 - RW'(1)) ? '0 : (row_ff + RW'(1));
         end else begin
            col_in = col_ff + SW'(1);
         end
      end
   end

   dmps_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_SIZE)
   ) u_row_sums (
      .clock     (clock),
      .wr_en     (s1_fire),
      .wr_addr   (s1_addr_ff),
      .wr_data   (sum),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // ---------------- update stage: best parent, add, write back ----------------
   assign src_a = s1_ctrl_ff.fwd_a ? fwd_data_ff : rd_data_a;
   assign src_b = s1_ctrl_ff.fwd_b ? fwd_data_ff : rd_data_b;

   always_comb begin
      unique case (s1_ctrl_ff.kind)
         ROW_UPPER: begin
            par_a = s1_ctrl_ff.use_left ? left_hold_ff : '0;
            par_b = s1_ctrl_ff.use_same ? src_a : '0;
         end
         ROW_LOWER: begin
            par_a = src_a;
            par_b = src_b;
         end
         default: begin
            par_a = '0;
            par_b = '0;
         end
      endcase
   end

   assign best = (par_a > par_b) ? par_a : par_b;
   assign sum  = best + SUM_W'(s1_value_ff);

   always_comb begin
      left_hold_in = left_hold_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_total_in = out_total_ff;
      if (csr_valid) begin
         left_hold_in = '0;
      end else if (s1_fire) begin
         // upper half keeps the old column value before it is overwritten
         if (s1_ctrl_ff.row_end) begin
            left_hold_in = '0;
         end else if (s1_ctrl_ff.kind == ROW_UPPER) begin
            left_hold_in = par_b;
         end
         if (s1_ctrl_ff.last_cell) begin
            out_valid_in = 1'b1;
            out_total_in = sum;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_best_total = out_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SW'(1);
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         left_hold_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         left_hold_ff <= left_hold_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff   <= s1_ctrl_in;
      s1_addr_ff   <= s1_addr_in;
      s1_value_ff  <= s1_value_in;
      fwd_data_ff  <= fwd_data_in;
      out_total_ff <= out_total_in;
   end

endmodule

`default_nettype wire

// ===== design/dmps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_diamond_max_path_sum.sv =====
`timescale 1ns / 1ps

module tb_diamond_max_path_sum;
   import dmps_pkg::*;

   localparam int DIAMOND_MAX     = MAX_SIZE_DEFAULT;
   localparam int IDLE_PERCENT    = 19;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_CELLS    = 700;
   localparam int PRESSURE_PHASE  = 0;
   localparam int QUIET_FIRST     = 100;
   localparam int QUIET_LAST      = 400;
   localparam int PRINT_LIMIT     = 40;
   localparam int DUE_DEPTH       = 64;

   typedef enum logic [1:0] {
      STEP_SIZE,
      STEP_FILL
   } step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic [CSR_W-1:0]  size;
      logic [CELL_W-1:0] value;
      logic              random_fill;
      logic [15:0]       cell_count;   // 0 runs the whole diamond
      logic              known;
      logic [SUM_W-1:0]  total;
   } directed_step_type;

   localparam int DIRECTED_STEPS = 18;

   directed_step_type directed_steps [DIRECTED_STEPS] = '{
      '{STEP_FILL, 8'd0,   16'h0000, 1'b0, 16'd0, 1'b1, 24'd0},        // size 1 after reset
      '{STEP_FILL, 8'd0,   16'hFFFF, 1'b0, 16'd0, 1'b1, 24'd65535},
      '{STEP_SIZE, 8'd0,   16'h0000, 1'b0, 16'd0, 1'b0, 24'd0},        // zero acts as one
      '{STEP_FILL, 8'd0,   16'hFFFF, 1'b0, 16'd0, 1'b1, 24'd65535},
      '{STEP_SIZE, 8'd2,   16'h0000, 1'b0, 16'd0, 1'b0, 24'd0},
      '{STEP_FILL, 8'd0,   16'h0001, 1'b0, 16'd0, 1'b1, 24'd3},
      '{STEP_FILL, 8'd0,   16'h0000, 1'b1, 16'd0, 1'b0, 24'd0},
      '{STEP_SIZE, 8'd3,   16'h0000, 1'b0, 16'd0, 1'b0, 24'd0},
      '{STEP_FILL, 8'd0,   16'h0000, 1'b1, 16'd4, 1'b0, 24'd0},        // stop mid-diamond
      '{STEP_SIZE, 8'd3,   16'h0000, 1'b0, 16'd0, 1'b0, 24'd0},        // write restarts it
      '{STEP_FILL, 8'd0,   16'h0000, 1'b0, 16'd0, 1'b1, 24'd0},
      '{STEP_FILL, 8'd0,   16'h0000, 1'b1, 16'd0, 1'b0, 24'd0},
      '{STEP_SIZE, 8'd5,   16'h0000, 1'b0, 16'd0, 1'b0, 24'd0},
      '{STEP_FILL, 8'd0,   16'h0000, 1'b1, 16'd0, 1'b0, 24'd0},
      '{STEP_SIZE, 8'd128, 16'h0000, 1'b0, 16'd0, 1'b0, 24'd0},
      '{STEP_FILL, 8'd0,   16'hFFFF, 1'b0, 16'd200, 1'b0, 24'd0},      // largest cells, partial
      '{STEP_SIZE, 8'd255, 16'h0000, 1'b0, 16'd0, 1'b0, 24'd0},        // clamps to the maximum
      '{STEP_FILL, 8'd0,   16'h0000, 1'b1, 16'd100, 1'b0, 24'd0}
   };

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   wire               req_ready;
   logic [CELL_W-1:0] req_cell_value   = '0;
   wire               rsp_valid;
   logic              rsp_ready        = 1'b0;
   wire  [SUM_W-1:0]  rsp_best_total;
   logic              csr_valid        = 1'b0;
   wire               csr_ready;
   logic [CSR_W-1:0]  csr_diamond_size = '0;

   bit          req_idle_on    = 1'b1;
   bit          rsp_idle_on    = 1'b1;
   int unsigned holds_asked    = 0;
   int unsigned holds_done     = 0;
   int unsigned mismatch_count = 0;

   // running state of the expected path sums
   logic [CSR_W-1:0] size_setting = 8'd1;
   logic [SUM_W-1:0] best_row [DIAMOND_MAX];
   int unsigned      row_pos      = 0;
   int unsigned      col_pos      = 0;
   logic [SUM_W-1:0] left_hold    = '0;

   // expected totals in transfer order, written by the sender, read by the monitor
   logic [SUM_W-1:0] totals_due [DUE_DEPTH];
   int unsigned      due_wr       = 0;
   int unsigned      due_rd       = 0;

   diamond_max_path_sum i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_best_total   (rsp_best_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_diamond_size (csr_diamond_size)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned clamped_size(input logic [CSR_W-1:0] size);
      if (size == 0) return 1;
      if (size > DIAMOND_MAX) return DIAMOND_MAX;
      return int'(size);
   endfunction

   // adds one cell to the best row sums, returns 1 with the total on the bottom cell
   function automatic bit path_sum_step(input logic [CELL_W-1:0] value,
                                        output logic [SUM_W-1:0] total);
      int unsigned      s;
      int unsigned      len;
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
      logic [SUM_W-1:0] sum;
      s     = clamped_size(size_setting);
      len   = (row_pos < s) ? row_pos + 1 : 2 * s - 1 - row_pos;
      a     = '0;
      b     = '0;
      total = '0;
      if (row_pos > 0 && row_pos < s) begin
         a         = (col_pos > 0) ? left_hold : '0;
         b         = (col_pos < row_pos) ? best_row[col_pos] : '0;
         left_hold = b;
      end else if (row_pos >= s) begin
         a = best_row[col_pos];
         b = best_row[(col_pos + 1) % DIAMOND_MAX];
      end
      sum               = ((a > b) ? a : b) + SUM_W'(value);
      best_row[col_pos] = sum;
      col_pos++;
      if (col_pos >= len) begin
         col_pos   = 0;
         left_hold = '0;
         row_pos++;
         if (row_pos >= 2 * s - 1) begin
            row_pos = 0;
            total   = sum;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [CELL_W-1:0] random_cell_value();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) return '1;
      if (pick < 30) return CELL_W'($urandom_range(15));
      return CELL_W'($urandom);
   endfunction

   task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                  input logic [SUM_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: %s: best_total got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // valid stays high across back-to-back cells and is only lowered on a gap
   task automatic offer_cell(input logic [CELL_W-1:0] value, input bit known,
                             input logic [SUM_W-1:0] known_total);
      logic [SUM_W-1:0] total;
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (path_sum_step(value, total)) begin
         totals_due[due_wr % DUE_DEPTH] = known ? known_total : total;
         due_wr++;
      end
   endtask

   task automatic run_cells(input int unsigned count, input bit random_fill,
                            input logic [CELL_W-1:0] value, input bit known,
                            input logic [SUM_W-1:0] known_total);
      for (int unsigned n = 0; n < count; n++)
         offer_cell(random_fill ? random_cell_value() : value, known, known_total);
   endtask

   // cells without a result may still be in the pipe when the queue empties
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_W-1:0] size);
      wait_idle();
      csr_valid        <= 1'b1;
      csr_diamond_size <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      size_setting = size;
      row_pos      = 0;
      col_pos      = 0;
      left_hold    = '0;
   endtask

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= !(rsp_idle_on && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_wr == due_rd) begin
            report_mismatch("unexpected transfer", rsp_best_total, '0);
         end else begin
            if (rsp_best_total !== totals_due[due_rd % DUE_DEPTH])
               report_mismatch("wrong total", rsp_best_total,
                               totals_due[due_rd % DUE_DEPTH]);
            due_rd++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      directed_step_type step;
      int unsigned       size_pick;
      int unsigned       diamonds;
      int unsigned       cells;
      int unsigned       count;
      int unsigned       phase;
      int unsigned       random_sent;
      bit                broken;
      logic [CSR_W-1:0]  size;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         step = directed_steps[i];
         if (step.kind == STEP_SIZE) begin
            write_size(step.size);
         end else begin
            count = int'(step.cell_count);
            if (count == 0) count = clamped_size(size_setting) ** 2;
            run_cells(count, step.random_fill, step.value, step.known, step.total);
         end
      end

      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_CELLS) begin
         size_pick   = $urandom_range(99);
         if (phase == PRESSURE_PHASE) size = 8'd1;
         else if (size_pick < 5) size = '0;
         else if (size_pick < 70) size = CSR_W'($urandom_range(1, 6));
         else size = CSR_W'($urandom_range(7, 16));
         write_size(size);
         cells = clamped_size(size) ** 2;
         if (phase == PRESSURE_PHASE) begin
            // one-cell diamonds against a stalled receiver fill the output side
            holds_asked++;
            diamonds = 40;
         end else begin
            diamonds = $urandom_range(1, 4);
         end
         broken = 1'b0;
         for (int unsigned d = 0; d < diamonds && !broken; d++) begin
            // no idling on either side while the cell count is inside the quiet window
            req_idle_on = !(random_sent >= QUIET_FIRST && random_sent < QUIET_LAST);
            rsp_idle_on = req_idle_on;
            count = cells;
            if (cells > 1 && $urandom_range(99) < 8) begin
               count  = $urandom_range(1, cells - 1);
               broken = 1'b1;
            end
            run_cells(count, 1'b1, '0, 1'b0, '0);
            random_sent += count;
         end
         phase++;
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/dmps_pkg.sv
design/dmps_ram.sv
design/diamond_max_path_sum.sv
sim/tb_diamond_max_path_sum.sv
